>>> sv/ps2_host_bit_engine_assert.svh
// Assertion macros for the PS/2 host bit engine checker.
// Needs a clk and an active-low rst_n in the scope of use.
`ifndef PS2_HOST_BIT_ENGINE_ASSERT_SVH
`define PS2_HOST_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PS2HBE_ASSERT_NOW(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("ps2 host bit engine: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PS2HBE_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("ps2 host bit engine: next-cycle check failed");

`endif

>>> sv/ps2hbe_pkg.sv
// Types and constants of the PS/2 host bit engine.
// No dependencies; used by the engine core, the top level and the checker.
package ps2hbe_pkg;

    localparam int DATA_BITS = 8;
    localparam int CNT_W     = 4;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_RX_DATA   = 8'b0000_0010,
        PH_RX_PARITY = 8'b0000_0100,
        PH_RX_STOP   = 8'b0000_1000,
        PH_TX_DATA   = 8'b0001_0000,
        PH_TX_PARITY = 8'b0010_0000,
        PH_TX_STOP   = 8'b0100_0000,
        PH_TX_ACK    = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_PARITY = 2'd1,
        STATUS_STOP   = 2'd2
    } status_t;

    typedef enum logic {
        REQ_EDGE = 1'b0,
        REQ_SEND = 1'b1
    } req_t;

    typedef struct packed {
        phase_t             phase;
        logic [CNT_W-1:0]   bit_count;
        logic [7:0]         shift_bits;
        logic               parity_acc;
        logic               drv_en;
        logic               drv_lvl;
    } state_t;

    typedef struct packed {
        logic       drive_enable;
        logic       drive_level;
        logic [7:0] rx_byte;
        logic       rx_done;
        status_t    rx_status;
        logic       tx_done;
        logic       busy_reject;
    } result_t;

endpackage

>>> sv/ps2hbe_core.sv
// Next-state and result logic for one event of the PS/2 host bit engine.
// Depends on ps2hbe_pkg.
module ps2hbe_core (
    input  ps2hbe_pkg::state_t  state,
    input  logic                req_type,
    input  logic                line_bit,
    input  logic [7:0]          send_byte,
    output ps2hbe_pkg::state_t  state_next,
    output ps2hbe_pkg::result_t result
);
    import ps2hbe_pkg::*;

    logic [CNT_W-1:0] count_inc;
    logic             count_last;

    assign count_inc  = state.bit_count + CNT_W'(1);
    assign count_last = (count_inc >= CNT_W'(DATA_BITS));

    always_comb
    begin
        state_next = state;
        result     = '0;
        result.rx_status = STATUS_OK;

        if (req_t'(req_type) == REQ_SEND)
        begin
            if (state.phase == PH_IDLE)
            begin
                // load the byte and drive the start bit
                state_next.shift_bits = send_byte;
                state_next.bit_count  = '0;
                state_next.parity_acc = 1'b1;
                state_next.drv_en     = 1'b1;
                state_next.drv_lvl    = 1'b0;
                state_next.phase      = PH_TX_DATA;
            end
            else
            begin
                result.busy_reject = 1'b1;
            end
        end
        else
        begin
            unique case (state.phase)
                PH_IDLE:
                begin
                    if (!line_bit)
                    begin
                        state_next.phase      = PH_RX_DATA;
                        state_next.bit_count  = '0;
                        state_next.shift_bits = '0;
                        state_next.parity_acc = 1'b1;
                    end
                end
                PH_RX_DATA:
                begin
                    if (!state.bit_count[CNT_W-1])
                        state_next.shift_bits[state.bit_count[2:0]] =
                            state.shift_bits[state.bit_count[2:0]] | line_bit;
                    state_next.parity_acc = state.parity_acc ^ line_bit;
                    state_next.bit_count  = count_inc;
                    if (count_last)
                        state_next.phase = PH_RX_PARITY;
                end
                PH_RX_PARITY:
                begin
                    // keep 1 on mismatch
                    state_next.parity_acc = line_bit ^ state.parity_acc;
                    state_next.phase      = PH_RX_STOP;
                end
                PH_RX_STOP:
                begin
                    result.rx_byte = state.shift_bits;
                    result.rx_done = 1'b1;
                    if (state.parity_acc)
                        result.rx_status = STATUS_PARITY;
                    else if (!line_bit)
                        result.rx_status = STATUS_STOP;
                    state_next.phase      = PH_IDLE;
                    state_next.bit_count  = '0;
                    state_next.parity_acc = 1'b1;
                end
                PH_TX_DATA:
                begin
                    state_next.drv_en     = 1'b1;
                    state_next.drv_lvl    = state.shift_bits[0];
                    state_next.parity_acc = state.parity_acc ^ state.shift_bits[0];
                    state_next.shift_bits = state.shift_bits >> 1;
                    state_next.bit_count  = count_inc;
                    if (count_last)
                        state_next.phase = PH_TX_PARITY;
                end
                PH_TX_PARITY:
                begin
                    state_next.drv_en  = 1'b1;
                    state_next.drv_lvl = state.parity_acc;
                    state_next.phase   = PH_TX_STOP;
                end
                PH_TX_STOP:
                begin
                    state_next.drv_en  = 1'b0;
                    state_next.drv_lvl = 1'b1;
                    state_next.phase   = PH_TX_ACK;
                end
                default:
                begin
                    // acknowledge edge, and recovery from any stray code
                    state_next.drv_en     = 1'b0;
                    state_next.drv_lvl    = 1'b1;
                    result.tx_done        = (state.phase == PH_TX_ACK);
                    state_next.phase      = PH_IDLE;
                    state_next.bit_count  = '0;
                    state_next.parity_acc = 1'b1;
                end
            endcase
        end

        result.drive_enable = state_next.drv_en;
        result.drive_level  = state_next.drv_lvl;
    end

endmodule

>>> sv/ps2_host_bit_engine.sv
// A beat's result is registered in out_reg, or parked in skid_reg while out_stall holds out_reg.
// Throughput: one input beat per cycle while in_stall is low; the frame state advances on each accepted beat.
// A two-entry result buffer (output register plus skid) keeps in_stall registered.
// Reset (rst_n low, asynchronous): phase idle, bit count 0, shift bits 0,
// parity seed 1, data line released, result buffer empty.
module ps2_host_bit_engine (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic       line_bit,
    input  logic [7:0] send_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       drive_enable,
    output logic       drive_level,
    output logic [7:0] rx_byte,
    output logic       rx_done,
    output logic [1:0] rx_status,
    output logic       tx_done,
    output logic       busy_reject
);
    import ps2hbe_pkg::*;

    // Frame state: advances once per accepted beat.
    state_t  state_reg, state_next;
    result_t result_new;

    // Result buffer: out_reg faces the consumer, skid_reg catches a beat
    // that arrives while out_reg is held by out_stall.
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic    in_accept;
    logic    out_free;

    // Stall input only when the skid entry is occupied.
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    ps2hbe_core u_core (
        .state      (state_reg),
        .req_type   (req_type),
        .line_bit   (line_bit),
        .send_byte  (send_byte),
        .state_next (state_next),
        .result     (result_new)
    );

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // drain the skid beat first; input is stalled this cycle
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result_new;
                out_valid_next = in_accept;
            end
        end
        else if (in_accept)
        begin
            // hold out_reg, park the new beat
            skid_next       = result_new;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_IDLE;
            state_reg.bit_count  <= '0;
            state_reg.shift_bits <= '0;
            state_reg.parity_acc <= 1'b1;
            state_reg.drv_en     <= 1'b0;
            state_reg.drv_lvl    <= 1'b1;
            out_valid_reg        <= 1'b0;
            skid_valid_reg       <= 1'b0;
        end
        else
        begin
            if (in_accept)
                state_reg <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign drive_enable = out_reg.drive_enable;
    assign drive_level  = out_reg.drive_level;
    assign rx_byte      = out_reg.rx_byte;
    assign rx_done      = out_reg.rx_done;
    assign rx_status    = out_reg.rx_status;
    assign tx_done      = out_reg.tx_done;
    assign busy_reject  = out_reg.busy_reject;

endmodule

>>> sv/ps2hbe_checker.sv
// Port-level checks for the PS/2 host bit engine, bound to the top level.
// Depends on ps2hbe_pkg and ps2_host_bit_engine_assert.svh.
module ps2hbe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       drive_enable,
    input logic [7:0] rx_byte,
    input logic       rx_done,
    input logic [1:0] rx_status,
    input logic       tx_done,
    input logic       busy_reject
);
    import ps2hbe_pkg::*;

`include "ps2_host_bit_engine_assert.svh"

    // a stalled result beat stays
`PS2HBE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
`PS2HBE_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(rx_byte) && $stable(rx_status))
    // receive fields are zero outside a finished frame
`PS2HBE_ASSERT_NOW(a_rx_quiet, out_valid && !rx_done, rx_byte == 8'd0 && rx_status == STATUS_OK)
    // a rejected request leaves no frame end behind
`PS2HBE_ASSERT_NOW(a_reject_alone, out_valid && busy_reject, !rx_done && !tx_done)
    // a receive frame ends with the line released
`PS2HBE_ASSERT_NOW(a_rx_released, out_valid && rx_done, !drive_enable && !tx_done && rx_status != 2'd3)

endmodule

bind ps2_host_bit_engine ps2hbe_checker u_ps2hbe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive_enable (drive_enable),
    .rx_byte      (rx_byte),
    .rx_done      (rx_done),
    .rx_status    (rx_status),
    .tx_done      (tx_done),
    .busy_reject  (busy_reject)
);
